[hdl/wav_header_parser_top_assert.svh]
// Assertion macros shared by the wav header parser RTL.
`ifndef WAV_HEADER_PARSER_TOP_ASSERT_SVH
`define WAV_HEADER_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define WHP_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wav header parser: property failed");

// Next-cycle implication, off during reset.
`define WHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wav header parser: property failed");

`endif

[hdl/whp_pkg.sv]
// Types, constants and helper functions of the wav header parser.
`default_nettype none

package whp_pkg;

   typedef enum logic [1:0] {
      PH_DONE,
      PH_HEADER,
      PH_SEARCH,
      PH_SIZE
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_NOT_RIFF,
      ST_MALFORMED,
      ST_NOT_PCM,
      ST_BAD_CHANNELS,
      ST_BAD_BITS,
      ST_NO_DATA
   } status_type;

   typedef logic [5:0] pos_type;

   localparam logic [31:0] ID_RIFF  = 32'h5249_4646;
   localparam logic [31:0] ID_WAVE  = 32'h5741_5645;
   localparam logic [31:0] ID_FMT   = 32'h666d_7420;
   localparam logic [31:0] ID_DATA  = 32'h6461_7461;
   localparam logic [15:0] FMT_PCM  = 16'h0001;
   localparam logic [31:0] FMT_SIZE = 32'd16;
   localparam logic [15:0] BITS_REQ = 16'd16;

   // Header checkpoints, in file order; each index names one check.
   localparam int NUM_CHECKS = 8;
   localparam logic [2:0] CHK_RIFF     = 3'd0;
   localparam logic [2:0] CHK_WAVE     = 3'd1;
   localparam logic [2:0] CHK_FMT      = 3'd2;
   localparam logic [2:0] CHK_FMT_SIZE = 3'd3;
   localparam logic [2:0] CHK_FORMAT   = 3'd4;
   localparam logic [2:0] CHK_CHANNELS = 3'd5;
   localparam logic [2:0] CHK_RATE     = 3'd6;
   localparam logic [2:0] CHK_BITS     = 3'd7;

   localparam pos_type LAST_HEADER_POS = 6'd35;

   localparam pos_type CHECK_POS [NUM_CHECKS] = '{
      6'd3, 6'd11, 6'd15, 6'd19, 6'd21, 6'd23, 6'd27, 6'd35
   };

   function automatic logic [31:0] swap32(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   // Window holds the four bytes ending at the checkpoint, newest in the low byte.
   function automatic logic check_pass(input logic [2:0] idx, input logic [31:0] win);
      logic [15:0] half;
      half = {win[7:0], win[15:8]};
      unique case (idx)
         CHK_RIFF:     return win == ID_RIFF;
         CHK_WAVE:     return win == ID_WAVE;
         CHK_FMT:      return win == ID_FMT;
         CHK_FMT_SIZE: return swap32(win) == FMT_SIZE;
         CHK_FORMAT:   return half == FMT_PCM;
         CHK_CHANNELS: return (half == 16'd1) || (half == 16'd2);
         CHK_RATE:     return 1'b1;
         CHK_BITS:     return half == BITS_REQ;
         default:      return 1'b1;
      endcase
   endfunction

   function automatic status_type check_status(input logic [2:0] idx);
      unique case (idx)
         CHK_RIFF:     return ST_NOT_RIFF;
         CHK_WAVE:     return ST_MALFORMED;
         CHK_FMT:      return ST_MALFORMED;
         CHK_FMT_SIZE: return ST_NOT_PCM;
         CHK_FORMAT:   return ST_NOT_PCM;
         CHK_CHANNELS: return ST_BAD_CHANNELS;
         CHK_BITS:     return ST_BAD_BITS;
         default:      return ST_OK;
      endcase
   endfunction

endpackage

`default_nettype wire

[hdl/whp_if.sv]
// Valid/ready channel interfaces for the byte input and the result output.
`default_nettype none

interface whp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       first_byte;
   logic       last_byte;

   modport source(output valid, output file_byte, output first_byte, output last_byte,
                  input ready);
   modport sink(input valid, input file_byte, input first_byte, input last_byte,
                output ready);
endinterface

interface whp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [1:0]  channels;
   logic [31:0] sample_rate;
   logic [31:0] data_size;

   modport source(output valid, output status, output channels, output sample_rate,
                  output data_size, input ready);
   modport sink(input valid, input status, input channels, input sample_rate,
                input data_size, output ready);
endinterface

`default_nettype wire

[hdl/wav_header_parser_top.sv]
// RIFF/WAVE PCM header parser: one file byte per transfer, one result per file.
//
// req carries the file one byte per transfer, with first_byte marking the
// start of a file (restarting any parse in progress) and last_byte its end.
// rsp carries one result per file: status, channel count, sample rate and
// data chunk size. A result is produced at the first failing header check,
// after the four size bytes that follow "data", or at the final byte; a file
// that ends early is treated as padded with zero bytes. Bytes after the
// result, or with no file open, are dropped without a result.
//
// Throughput is one byte per cycle while req.ready is high: each byte is evaluated
// against all header checkpoints at once in a single combinational pass from
// the parse state registers. The result is in the output register the cycle
// after the transfer of the byte that decides it.
// The output register decouples the sides; req.ready drops only while a
// result is held and rsp.ready is low, so a stalled receiver stalls input.
// Synchronous reset puts the parser in the idle state (no file open) and
// empties the output register.
`default_nettype none

`include "wav_header_parser_top_assert.svh"

module wav_header_parser_top (
   input  wire logic  clock,
   input  wire logic  reset,
   whp_req_if.sink    req,
   whp_rsp_if.source  rsp
);

   whp_pkg::phase_type  phase_ff, phase_in;
   whp_pkg::pos_type    pos_ff, pos_in;
   logic [31:0]         window_ff, window_in;
   logic [1:0]          chan_ff, chan_in;
   logic [31:0]         rate_ff, rate_in;
   logic [31:0]         size_ff, size_in;

   logic                rsp_valid_ff;
   whp_pkg::status_type rsp_status_ff;
   logic [1:0]          rsp_chan_ff;
   logic [31:0]         rsp_rate_ff;
   logic [31:0]         rsp_size_ff;

   logic in_xfer;

   // State as seen by this byte; first_byte restarts the parse.
   whp_pkg::phase_type ph_eff;
   whp_pkg::pos_type   pos_eff;
   logic [31:0]        win_eff;
   logic [1:0]         chan_eff;
   logic [31:0]        rate_eff;
   logic [31:0]        size_eff;
   logic [31:0]        cur_win;

   // Header checkpoint evaluation.
   logic [31:0]                 chk_win [whp_pkg::NUM_CHECKS];
   logic [whp_pkg::NUM_CHECKS-1:0] chk_active;
   logic [whp_pkg::NUM_CHECKS-1:0] chk_pass;
   logic [whp_pkg::NUM_CHECKS-1:0] chk_reach;
   logic                        hdr_fail;
   whp_pkg::status_type         hdr_status;
   logic [1:0]                  hdr_chan;
   logic [31:0]                 hdr_rate;
   logic [31:0]                 size_acc;

   // Result of this byte.
   logic                res_valid;
   whp_pkg::status_type res_status;
   logic [1:0]          res_chan;
   logic [31:0]         res_rate;
   logic [31:0]         res_size;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign in_xfer   = req.valid && req.ready;

   always_comb begin
      if (req.first_byte) begin
         ph_eff   = whp_pkg::PH_HEADER;
         pos_eff  = '0;
         win_eff  = '0;
         chan_eff = '0;
         rate_eff = '0;
         size_eff = '0;
      end else begin
         ph_eff   = phase_ff;
         pos_eff  = pos_ff;
         win_eff  = window_ff;
         chan_eff = chan_ff;
         rate_eff = rate_ff;
         size_eff = size_ff;
      end
      cur_win  = {win_eff[23:0], req.file_byte};
      size_acc = size_eff | ({24'd0, req.file_byte} << {pos_eff[1:0], 3'b000});
   end

   // Every checkpoint at or after this byte sees the window it would hold if
   // the rest of the file were zero bytes; only the current one counts unless
   // this is the final byte.
   always_comb begin
      logic [5:0] ahead;
      for (int i = 0; i < whp_pkg::NUM_CHECKS; i++) begin
         ahead = whp_pkg::CHECK_POS[i] - pos_eff;
         chk_active[i] = (pos_eff == whp_pkg::CHECK_POS[i]) ||
                         (req.last_byte && (pos_eff < whp_pkg::CHECK_POS[i]));
         chk_win[i]    = (ahead > 6'd3) ? 32'd0 : (cur_win << {ahead[1:0], 3'b000});
         chk_pass[i]   = whp_pkg::check_pass(3'(i), chk_win[i]);
      end
   end

   always_comb begin
      hdr_fail   = 1'b0;
      hdr_status = whp_pkg::ST_OK;
      for (int i = 0; i < whp_pkg::NUM_CHECKS; i++) begin
         chk_reach[i] = chk_active[i] && !hdr_fail;
         if (chk_reach[i] && !chk_pass[i]) begin
            hdr_fail   = 1'b1;
            hdr_status = whp_pkg::check_status(3'(i));
         end
      end
      hdr_chan = (chk_reach[whp_pkg::CHK_CHANNELS] && chk_pass[whp_pkg::CHK_CHANNELS]) ?
                 chk_win[whp_pkg::CHK_CHANNELS][9:8] : chan_eff;
      hdr_rate = chk_reach[whp_pkg::CHK_RATE] ?
                 whp_pkg::swap32(chk_win[whp_pkg::CHK_RATE]) : rate_eff;
   end

   // Next state.
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      window_in = window_ff;
      chan_in   = chan_ff;
      rate_in   = rate_ff;
      size_in   = size_ff;
      if (in_xfer) begin
         phase_in  = ph_eff;
         pos_in    = pos_eff;
         window_in = win_eff;
         chan_in   = chan_eff;
         rate_in   = rate_eff;
         size_in   = size_eff;
         unique case (ph_eff)
            whp_pkg::PH_HEADER: begin
               window_in = cur_win;
               chan_in   = hdr_chan;
               rate_in   = hdr_rate;
               pos_in    = pos_eff + 6'd1;
               priority if (hdr_fail || req.last_byte) begin
                  phase_in = whp_pkg::PH_DONE;
               end else if (pos_eff == whp_pkg::LAST_HEADER_POS) begin
                  phase_in = whp_pkg::PH_SEARCH;
               end
            end
            whp_pkg::PH_SEARCH: begin
               window_in = cur_win;
               priority if (req.last_byte) begin
                  phase_in = whp_pkg::PH_DONE;
               end else if (cur_win == whp_pkg::ID_DATA) begin
                  phase_in = whp_pkg::PH_SIZE;
                  pos_in   = '0;
                  size_in  = '0;
               end
            end
            whp_pkg::PH_SIZE: begin
               size_in = size_acc;
               pos_in  = pos_eff + 6'd1;
               if (req.last_byte || (pos_eff[1:0] == 2'd3)) begin
                  phase_in = whp_pkg::PH_DONE;
               end
            end
            whp_pkg::PH_DONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   // Result of the current byte.
   always_comb begin
      res_valid  = 1'b0;
      res_status = whp_pkg::ST_OK;
      res_chan   = chan_eff;
      res_rate   = rate_eff;
      res_size   = '0;
      unique case (ph_eff)
         whp_pkg::PH_HEADER: begin
            res_chan = hdr_chan;
            res_rate = hdr_rate;
            if (hdr_fail) begin
               res_valid  = 1'b1;
               res_status = hdr_status;
            end else if (req.last_byte) begin
               res_valid  = 1'b1;
               res_status = whp_pkg::ST_NO_DATA;
            end
         end
         whp_pkg::PH_SEARCH: begin
            // A final byte that completes the id reports an empty data chunk.
            if (req.last_byte) begin
               res_valid  = 1'b1;
               res_status = (cur_win == whp_pkg::ID_DATA) ? whp_pkg::ST_OK
                                                          : whp_pkg::ST_NO_DATA;
            end
         end
         whp_pkg::PH_SIZE: begin
            if (req.last_byte || (pos_eff[1:0] == 2'd3)) begin
               res_valid  = 1'b1;
               res_status = whp_pkg::ST_OK;
               res_size   = size_acc;
            end
         end
         whp_pkg::PH_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= whp_pkg::PH_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (in_xfer && res_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      window_ff <= window_in;
      chan_ff   <= chan_in;
      rate_ff   <= rate_in;
      size_ff   <= size_in;
      if (in_xfer && res_valid) begin
         rsp_status_ff <= res_status;
         rsp_chan_ff   <= res_chan;
         rsp_rate_ff   <= res_rate;
         rsp_size_ff   <= res_size;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.channels    = rsp_chan_ff;
   assign rsp.sample_rate = rsp_rate_ff;
   assign rsp.data_size   = rsp_size_ff;

   `WHP_ASSERT_NEXT(a_result_loaded, clock, reset, in_xfer && res_valid,
                    rsp_valid_ff && (rsp_status_ff == $past(res_status)))
   `WHP_ASSERT_HOLDS(a_result_needs_transfer, clock, reset, $rose(rsp_valid_ff),
                     $past(in_xfer))
   `WHP_ASSERT_HOLDS(a_ok_has_channels, clock, reset,
                     rsp_valid_ff && (rsp_status_ff == whp_pkg::ST_OK),
                     (rsp_chan_ff == 2'd1) || (rsp_chan_ff == 2'd2))
   `WHP_ASSERT_HOLDS(a_size_only_on_ok, clock, reset,
                     rsp_valid_ff && (rsp_status_ff != whp_pkg::ST_OK),
                     rsp_size_ff == 32'd0)
   `WHP_ASSERT_HOLDS(a_search_after_channels, clock, reset,
                     (phase_ff == whp_pkg::PH_SEARCH) || (phase_ff == whp_pkg::PH_SIZE),
                     chan_ff != 2'd0)

endmodule

`default_nettype wire
